// ===== hw/rtl/rational_accumulator_defines.svh =====
// Assertion helpers for the verification checker of the rational accumulator.
`ifndef RATIONAL_ACCUMULATOR_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_DEFINES_SVH

// Checked on every rising edge outside reset.
`define RACC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RACC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/racc_pkg.sv =====
package racc_pkg;

  // Command codes carried by an input item.
  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_CMP  = 3'd5;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Operand pairs fed to the shared multiplier.
  typedef enum logic [2:0] {
    MSEL_AN_OD,
    MSEL_ON_AD,
    MSEL_AD_OD,
    MSEL_AN_ON,
    MSEL_AD_ON
  } mul_sel_e;

  // What is done with the registered product.
  typedef enum logic [2:0] {
    APPLY_NUM_SET,
    APPLY_NUM_ADD,
    APPLY_NUM_SUB,
    APPLY_DEN_SET,
    APPLY_LOAD
  } apply_e;

  typedef struct packed {
    mul_sel_e   sel;
    apply_e     op;
    logic       last;
  } prog_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       latch;
    logic       mul_go;
    mul_sel_e   mul_sel;
    logic       apply_go;
    apply_e     apply_op;
    logic       prep;
    logic       store_zero;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       div_save;
    logic       div_den;
    logic       fin;
    logic       out_load;
    logic [1:0] status;
    logic       eq;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       od_zero;
    logic       on_zero;
    logic       num_zero;
    logic       gcd_done;
    logic       ovf;
  } stat_t;

  // Product sequence of each arithmetic command.
  function automatic prog_t prog_step(input logic [2:0] cmd, input logic [1:0] step);
    prog_t p;
    p = '{sel: MSEL_AN_OD, op: APPLY_NUM_SET, last: 1'b1};
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        case (step)
          2'd0:    p = '{sel: MSEL_AN_OD, op: APPLY_NUM_SET, last: 1'b0};
          2'd1:    p = '{sel: MSEL_ON_AD,
                         op: (cmd == CMD_ADD) ? APPLY_NUM_ADD : APPLY_NUM_SUB,
                         last: 1'b0};
          default: p = '{sel: MSEL_AD_OD, op: APPLY_DEN_SET, last: 1'b1};
        endcase
      end
      CMD_MUL: begin
        if (step == 2'd0) begin
          p = '{sel: MSEL_AN_ON, op: APPLY_NUM_SET, last: 1'b0};
        end else begin
          p = '{sel: MSEL_AD_OD, op: APPLY_DEN_SET, last: 1'b1};
        end
      end
      CMD_DIV: begin
        if (step == 2'd0) begin
          p = '{sel: MSEL_AN_OD, op: APPLY_NUM_SET, last: 1'b0};
        end else begin
          p = '{sel: MSEL_AD_ON, op: APPLY_DEN_SET, last: 1'b1};
        end
      end
      CMD_CMP: begin
        if (step == 2'd0) begin
          p = '{sel: MSEL_AN_OD, op: APPLY_NUM_SET, last: 1'b0};
        end else begin
          p = '{sel: MSEL_ON_AD, op: APPLY_NUM_SUB, last: 1'b1};
        end
      end
      default: p = '{sel: MSEL_AN_OD, op: APPLY_NUM_SET, last: 1'b1};
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/racc_if.sv =====
interface racc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] operand_numerator;
  logic signed [31:0] operand_denominator;

  modport source (output valid, cmd, operand_numerator, operand_denominator, input ready);
  modport sink   (input valid, cmd, operand_numerator, operand_denominator, output ready);
endinterface

interface racc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_numerator;
  logic [30:0]        result_denominator;
  logic               is_equal;
  logic [1:0]         status;

  modport source (output valid, result_numerator, result_denominator, is_equal, status,
                  input ready);
  modport sink   (input valid, result_numerator, result_denominator, is_equal, status,
                  output ready);
endinterface

// ===== hw/rtl/racc_datapath.sv =====
module racc_datapath #(
  parameter int W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [2:0]            cmd_i,
  input  logic signed [31:0]    op_num_i,
  input  logic signed [31:0]    op_den_i,
  input  racc_pkg::ctrl_t       ctrl_i,
  output racc_pkg::stat_t       stat_o,
  output logic signed [31:0]    res_num_o,
  output logic [30:0]           res_den_o,
  output logic                  res_eq_o,
  output logic [1:0]            res_status_o
);
  import racc_pkg::*;

  localparam int P = 2 * W + 2;
  localparam logic [P-1:0] LIM = P'(1) << (W - 1);

  logic signed [W-1:0] acc_num_q, acc_num_d;
  logic [W-2:0]        acc_den_q, acc_den_d;
  logic [2:0]          cmd_q;
  logic signed [W:0]   on_q, od_q;
  logic                od_zero_q, on_zero_q;
  logic signed [P-1:0] prod_q, num_q, den_q;
  logic                neg_q;
  logic [P-1:0]        a_q, b_q, un_q, ud_q, quo_q, rem_q;

  logic signed [W-1:0] on_w, od_w;
  logic signed [W:0]   on_x, od_x, an_x, ad_x, mul_a, mul_b;
  logic [P:0]          div_r;
  logic                ovf;

  assign on_w = op_num_i[W-1:0];
  assign od_w = op_den_i[W-1:0];
  assign on_x = (W+1)'(on_w);
  assign od_x = (W+1)'(od_w);
  assign an_x = (W+1)'(acc_num_q);
  assign ad_x = signed'({2'b00, acc_den_q});

  always_comb begin
    case (ctrl_i.mul_sel)
      MSEL_AN_OD: begin mul_a = an_x; mul_b = od_q; end
      MSEL_ON_AD: begin mul_a = on_q; mul_b = ad_x; end
      MSEL_AD_OD: begin mul_a = ad_x; mul_b = od_q; end
      MSEL_AN_ON: begin mul_a = an_x; mul_b = on_q; end
      default:    begin mul_a = ad_x; mul_b = on_q; end
    endcase
  end

  assign div_r = {rem_q, quo_q[P-1]};
  assign ovf   = (ud_q > LIM - P'(1)) || (neg_q ? (un_q > LIM) : (un_q > LIM - P'(1)));

  always_comb begin
    acc_num_d = acc_num_q;
    acc_den_d = acc_den_q;
    if (ctrl_i.store_zero) begin
      acc_num_d = '0;
      acc_den_d = (W-1)'(1);
    end else if (ctrl_i.fin && !ovf) begin
      acc_num_d = neg_q ? -signed'(un_q[W-1:0]) : signed'(un_q[W-1:0]);
      acc_den_d = ud_q[W-2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_num_q <= W'(1);
      acc_den_q <= (W-1)'(1);
    end else begin
      acc_num_q <= acc_num_d;
      acc_den_q <= acc_den_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q     <= cmd_i;
      on_q      <= od_w[W-1] ? -on_x : on_x;
      od_q      <= od_w[W-1] ? -od_x : od_x;
      od_zero_q <= (od_w == '0);
      on_zero_q <= (on_w == '0);
    end
    if (ctrl_i.mul_go) begin
      prod_q <= P'(mul_a * mul_b);
    end
    if (ctrl_i.apply_go) begin
      case (ctrl_i.apply_op)
        APPLY_NUM_SET: num_q <= prod_q;
        APPLY_NUM_ADD: num_q <= num_q + prod_q;
        APPLY_NUM_SUB: num_q <= num_q - prod_q;
        APPLY_DEN_SET: den_q <= prod_q;
        default: begin
          num_q <= P'(on_q);
          den_q <= P'(od_q);
        end
      endcase
    end
    if (ctrl_i.prep) begin
      neg_q <= num_q[P-1] ^ den_q[P-1];
      a_q   <= num_q[P-1] ? unsigned'(-num_q) : unsigned'(num_q);
      b_q   <= den_q[P-1] ? unsigned'(-den_q) : unsigned'(den_q);
      un_q  <= num_q[P-1] ? unsigned'(-num_q) : unsigned'(num_q);
      ud_q  <= den_q[P-1] ? unsigned'(-den_q) : unsigned'(den_q);
    end else if (ctrl_i.gcd_step) begin
      // Binary gcd; a common factor of two comes straight out of both terms.
      if (!a_q[0] && !b_q[0]) begin
        a_q  <= a_q >> 1;
        b_q  <= b_q >> 1;
        un_q <= un_q >> 1;
        ud_q <= ud_q >> 1;
      end else if (!a_q[0]) begin
        a_q <= a_q >> 1;
      end else if (!b_q[0]) begin
        b_q <= b_q >> 1;
      end else if (a_q > b_q) begin
        a_q <= a_q - b_q;
      end else begin
        b_q <= b_q - a_q;
      end
    end else if (ctrl_i.div_save) begin
      if (ctrl_i.div_den) begin
        ud_q <= quo_q;
      end else begin
        un_q <= quo_q;
      end
    end
    if (ctrl_i.div_init) begin
      rem_q <= '0;
      quo_q <= ctrl_i.div_den ? ud_q : un_q;
    end else if (ctrl_i.div_step) begin
      if (div_r >= {1'b0, a_q}) begin
        rem_q <= P'(div_r - {1'b0, a_q});
        quo_q <= {quo_q[P-2:0], 1'b1};
      end else begin
        rem_q <= div_r[P-1:0];
        quo_q <= {quo_q[P-2:0], 1'b0};
      end
    end
    if (ctrl_i.out_load) begin
      res_num_o    <= 32'(acc_num_q);
      res_den_o    <= 31'(acc_den_q);
      res_eq_o     <= ctrl_i.eq;
      res_status_o <= ctrl_i.status;
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.od_zero  = od_zero_q;
  assign stat_o.on_zero  = on_zero_q;
  assign stat_o.num_zero = (num_q == '0);
  assign stat_o.gcd_done = (b_q == '0);
  assign stat_o.ovf      = ovf;

endmodule

// ===== hw/rtl/racc_controller.sv =====
module racc_controller #(
  parameter int W = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  racc_pkg::stat_t stat_i,
  output racc_pkg::ctrl_t ctrl_o
);
  import racc_pkg::*;

  localparam int P  = 2 * W + 2;
  localparam int CW = $clog2(P);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_APPLY, S_PREP, S_GCD,
    S_DIV_INIT, S_DIV_STEP, S_DIV_SAVE, S_FIN, S_DONE
  } state_e;

  state_e      state_q;
  logic [1:0]  step_q;
  logic        div_den_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]  status_q;
  logic        eq_q;
  logic        out_valid_q;
  prog_t       prog;
  logic        out_free;

  assign prog       = prog_step(stat_i.cmd, step_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.mul_sel  = prog.sel;
    ctrl_o.apply_op = prog.op;
    ctrl_o.div_den  = div_den_q;
    ctrl_o.status   = status_q;
    ctrl_o.eq       = eq_q;
    case (state_q)
      S_IDLE:     ctrl_o.latch = in_valid_i;
      S_DECODE: begin
        if (stat_i.cmd == CMD_LOAD && !stat_i.od_zero) begin
          ctrl_o.apply_go = 1'b1;
          ctrl_o.apply_op = APPLY_LOAD;
        end
      end
      S_MUL:      ctrl_o.mul_go = 1'b1;
      S_APPLY:    ctrl_o.apply_go = 1'b1;
      S_PREP: begin
        if (stat_i.cmd != CMD_CMP) begin
          ctrl_o.store_zero = stat_i.num_zero;
          ctrl_o.prep       = !stat_i.num_zero;
        end
      end
      S_GCD:      ctrl_o.gcd_step = !stat_i.gcd_done;
      S_DIV_INIT: ctrl_o.div_init = 1'b1;
      S_DIV_STEP: ctrl_o.div_step = 1'b1;
      S_DIV_SAVE: ctrl_o.div_save = 1'b1;
      S_FIN:      ctrl_o.fin = 1'b1;
      S_DONE:     ctrl_o.out_load = out_free;
      default:    ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      div_den_q   <= 1'b0;
      cnt_q       <= '0;
      status_q    <= ST_OK;
      eq_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          status_q  <= ST_OK;
          eq_q      <= 1'b0;
          step_q    <= '0;
          div_den_q <= 1'b0;
          if (!(stat_i.cmd inside {[CMD_LOAD:CMD_CMP]})) begin
            state_q <= S_DONE;
          end else if (stat_i.od_zero) begin
            status_q <= ST_ZERO;
            state_q  <= S_DONE;
          end else if (stat_i.cmd == CMD_DIV && stat_i.on_zero) begin
            status_q <= ST_ZERO;
            state_q  <= S_DONE;
          end else if (stat_i.cmd == CMD_LOAD) begin
            state_q <= S_PREP;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_APPLY;
        S_APPLY: begin
          if (prog.last) begin
            state_q <= S_PREP;
          end else begin
            step_q  <= step_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        S_PREP: begin
          if (stat_i.cmd == CMD_CMP) begin
            eq_q    <= stat_i.num_zero;
            state_q <= S_DONE;
          end else if (stat_i.num_zero) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          if (stat_i.gcd_done) begin
            state_q <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(P - 1)) begin
            state_q <= S_DIV_SAVE;
          end
        end
        S_DIV_SAVE: begin
          if (div_den_q) begin
            state_q <= S_FIN;
          end else begin
            div_den_q <= 1'b1;
            state_q   <= S_DIV_INIT;
          end
        end
        S_FIN: begin
          status_q <= stat_i.ovf ? ST_OVF : ST_OK;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rational_accumulator.sv =====
// Channel | Direction | Payload
// req_i   | in        | cmd, operand_numerator, operand_denominator
// rsp_o   | out       | result_numerator, result_denominator, is_equal, status
//
// One item is worked on at a time; a new item is taken only once the previous one
// has been placed in the output register. An item that is rejected early (unknown
// command, zero denominator or divisor) goes straight to the final state. Compare
// forms two products and checks their difference for zero. An arithmetic item forms
// each product in the multiply state and applies it in the apply state, then a binary
// gcd runs at one step per cycle over 2*DATA_WIDTH+2 bits (up to about four steps per
// bit), then two restoring divisions; the gcd loop and the shared divider dominate.
// Reset sets the accumulator to 1/1 at once; there is no clearing pass.
// A result that is not taken holds the output register, and the block stalls in its
// final state until the register frees up.
module rational_accumulator #(
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  racc_in_if.sink  req_i,
  racc_out_if.source rsp_o
);
  import racc_pkg::*;

  // Commands and status between the sequencer and the arithmetic datapath.
  ctrl_t ctrl;
  stat_t stat;

  // The sequencer owns the handshakes and the status and equality flags.
  racc_controller #(
    .W (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // The datapath holds the accumulator, the shared multiplier, the gcd unit, the
  // divider and the result register.
  racc_datapath #(
    .W (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (req_i.cmd),
    .op_num_i     (req_i.operand_numerator),
    .op_den_i     (req_i.operand_denominator),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .res_num_o    (rsp_o.result_numerator),
    .res_den_o    (rsp_o.result_denominator),
    .res_eq_o     (rsp_o.is_equal),
    .res_status_o (rsp_o.status)
  );

endmodule

// ===== hw/rtl/racc_checker.sv =====
module racc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] out_den,
  input logic        out_eq,
  input logic [1:0]  out_status
);
  import racc_pkg::*;

  `include "rational_accumulator_defines.svh"

  // A result waiting to be taken stays offered.
  `RACC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  // The block works on one item at a time.
  `RACC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "second item taken early")
  // Stored denominators are always positive.
  `RACC_ASSERT(a_den_positive, out_valid |-> out_den != 31'd0, "zero denominator reported")
  // A rejected item never reports equality, and status 3 is never used.
  `RACC_ASSERT(a_status_eq, out_valid |-> (out_status != 2'd3) && !(out_status == ST_ZERO && out_eq), "bad status")
  // No result is offered during reset.
  `RACC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid, "result offered in reset")

endmodule

bind rational_accumulator racc_checker u_racc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .out_valid  (rsp_o.valid),
  .out_ready  (rsp_o.ready),
  .out_den    (rsp_o.result_denominator),
  .out_eq     (rsp_o.is_equal),
  .out_status (rsp_o.status)
);

// ===== test/rational_accumulator_test.sv =====
`timescale 1ns / 1ps

module rational_accumulator_test;
  import racc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  racc_in_if  req_if ();
  racc_out_if rsp_if ();

  rational_accumulator #(.DATA_WIDTH(32)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // One command item and one expected result item.
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } cmd_item_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               eq;
    logic [1:0]         status;
  } frac_result_t;

  cmd_item_t    pending_cmds[$];
  frac_result_t expected_fracs[$];

  // The predictor's own copy of the accumulator.
  logic signed [63:0] acc_num;
  logic signed [63:0] acc_den;

  int  fail_count = 0;
  int  idle_cycles = 0;
  int  hold_off = 0;
  bit  stim_done = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] gcd_of(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Reduce num/den, store it when it fits 32 bits, and return the status.
  function automatic logic [1:0] reduce_and_store(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
    logic        neg;
    logic [63:0] un, ud, g;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? -num : num;
    ud  = (den < 0) ? -den : den;
    if (un == 0) begin
      acc_num = 0;
      acc_den = 1;
      return ST_OK;
    end
    g  = gcd_of(un, ud);
    un = un / g;
    ud = ud / g;
    if (ud > 64'h7fff_ffff) return ST_OVF;
    if (neg ? (un > 64'h8000_0000) : (un > 64'h7fff_ffff)) return ST_OVF;
    acc_num = neg ? -$signed(un) : $signed(un);
    acc_den = $signed(ud);
    return ST_OK;
  endfunction

  function automatic frac_result_t predict_fraction(input cmd_item_t it);
    frac_result_t r;
    logic signed [63:0] on, od;
    logic signed [63:0] an, ad;
    on = it.num;
    od = it.den;
    an = acc_num;
    ad = acc_den;
    r.eq     = 1'b0;
    r.status = ST_OK;
    if (it.cmd <= CMD_CMP) begin
      if (od == 0) begin
        r.status = ST_ZERO;
      end else begin
        if (od < 0) begin
          on = -on;
          od = -od;
        end
        case (it.cmd)
          CMD_LOAD: r.status = reduce_and_store(on, od);
          CMD_ADD:  r.status = reduce_and_store(an * od + on * ad, ad * od);
          CMD_SUB:  r.status = reduce_and_store(an * od - on * ad, ad * od);
          CMD_MUL:  r.status = reduce_and_store(an * on, ad * od);
          CMD_DIV: begin
            if (on == 0) r.status = ST_ZERO;
            else r.status = reduce_and_store(an * od, ad * on);
          end
          default:  r.eq = (an * od == on * ad);
        endcase
      end
    end
    r.num = acc_num[31:0];
    r.den = acc_den[30:0];
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 0;
      3, 4:    return $signed($urandom);
      5:       return $signed($urandom_range(0, 65535)) - 32768;
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  task automatic queue_cmd(input logic [2:0] c, input logic signed [31:0] n,
                           input logic signed [31:0] d);
    cmd_item_t it;
    it.cmd = c;
    it.num = n;
    it.den = d;
    pending_cmds.push_back(it);
  endtask

  // Stimulus: a directed opening and then random commands. Small operands
  // dominate so that the accumulator wanders through many reachable values,
  // with full-range values mixed in to hit the overflow paths.
  initial begin
    logic [2:0] c;
    logic signed [31:0] d;
    queue_cmd(CMD_CMP, 1, 1);
    queue_cmd(CMD_LOAD, 6, -4);
    queue_cmd(CMD_ADD, 1, 2);
    queue_cmd(CMD_SUB, 3, 7);
    queue_cmd(CMD_MUL, -14, 3);
    queue_cmd(CMD_DIV, 5, -9);
    queue_cmd(CMD_DIV, 0, 5);
    queue_cmd(CMD_ADD, 3, 0);
    queue_cmd(CMD_CMP, 2, 0);
    queue_cmd(CMD_LOAD, 0, -8);
    queue_cmd(CMD_CMP, 0, 3);
    queue_cmd(3'd6, 1, 1);
    queue_cmd(3'd7, 32'sh8000_0000, 0);
    queue_cmd(CMD_LOAD, 32'sh8000_0000, 1);
    queue_cmd(CMD_LOAD, 32'sh8000_0000, -1);
    queue_cmd(CMD_LOAD, 32'sh7fff_ffff, 32'sh8000_0000);
    queue_cmd(CMD_CMP, 32'sh7fff_ffff, 32'sh8000_0000);
    queue_cmd(CMD_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
    queue_cmd(CMD_LOAD, 32'sh7fff_ffff, 1);
    queue_cmd(CMD_ADD, 1, 1);
    queue_cmd(CMD_MUL, 2, 1);
    queue_cmd(CMD_DIV, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_cmd(CMD_SUB, 32'sh8000_0000, 32'sh8000_0001);
    queue_cmd(CMD_LOAD, 32'hffff_ffff, 32'h7fff_ffff);
    for (int i = 0; i < 1630; i++) begin
      c = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(6, 7))
                                       : 3'($urandom_range(0, 5));
      d = pick_value();
      if ($urandom_range(0, 15) == 0) d = 0;
      queue_cmd(c, pick_value(), d);
    end
  end

  // Sender. The valid stays high across back-to-back items.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid               <= 1'b0;
      req_if.cmd                 <= '0;
      req_if.operand_numerator   <= '0;
      req_if.operand_denominator <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_fracs.push_back(predict_fraction({req_if.cmd, req_if.operand_numerator,
                                                   req_if.operand_denominator}));
      end
      if (!req_if.valid || req_if.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          req_if.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_item_t it;
          it = pending_cmds.pop_front();
          req_if.valid               <= 1'b1;
          req_if.cmd                 <= it.cmd;
          req_if.operand_numerator   <= it.num;
          req_if.operand_denominator <= it.den;
          if ($urandom_range(0, 3) == 0)
            in_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                                  : $urandom_range(1, 4);
        end else begin
          req_if.valid <= 1'b0;
          stim_done    <= 1'b1;
        end
      end
    end
  end

  // Receiver: random stalls, and one long hold-off once so that the input
  // backs up behind the full output register.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_fracs.size() == 0) begin
          $display("%0t: result with nothing expected: num %0d den %0d eq %0b st %0d",
                   $time, rsp_if.result_numerator, rsp_if.result_denominator,
                   rsp_if.is_equal, rsp_if.status);
          fail_count <= fail_count + 1;
        end else begin
          frac_result_t e;
          e = expected_fracs.pop_front();
          if (e !== {rsp_if.result_numerator, rsp_if.result_denominator,
                     rsp_if.is_equal, rsp_if.status}) begin
            $display("%0t: mismatch: expected %0d/%0d eq %0b st %0d, got %0d/%0d eq %0b st %0d",
                     $time, e.num, e.den, e.eq, e.status, rsp_if.result_numerator,
                     rsp_if.result_denominator, rsp_if.is_equal, rsp_if.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off     <= hold_off - 1;
        rsp_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap      <= out_gap - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0)
          out_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 500)
                                                 : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    acc_num = 1;
    acc_den = 1;
    repeat (3000) @(posedge clk_i);
    hold_off = 3000;
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rational_accumulator test failed");
      $finish;
    end
  end

  initial begin
    acc_num = 1;
    acc_den = 1;
    wait (stim_done && expected_fracs.size() == 0);
    repeat (500) @(posedge clk_i);
    if (fail_count == 0 && expected_fracs.size() == 0)
      $display("rational_accumulator test passed");
    else
      $display("rational_accumulator test failed");
    $finish;
  end

endmodule
